/* rtl/rrsjf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsjf_pkg: shared types and codes of the round-robin / SJF scheduler.
// Holds operation codes, result status codes and the front-to-back command.
// ----------------------------------------------------------------------------
package rrsjf_pkg;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_EXIT   = 2'd2;

  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOSWITCH = 3'd2;
  localparam logic [2:0] ST_PREEMPT  = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;
  localparam logic [2:0] ST_EJECT    = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;
  localparam logic [2:0] ST_HALTED   = 3'd7;

  localparam int unsigned JOB_W = 20;

  // Quantum in effect after reset, also held by slot zero.
  localparam logic [15:0] QUANTUM_RST = 16'd20;

  // One classified command as it passes from front to back.
  typedef struct packed {
    logic [1:0]       op;
    logic             is_high;
    logic [JOB_W-1:0] job;
  } cmd_t;

endpackage

/* rtl/rrsjf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsjf_front: command intake.
// Registers each started command and queues it for the execution engine in a
// two-entry FIFO, so the intake and the engine stall independently.
// ----------------------------------------------------------------------------
module rrsjf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rrsjf_pkg::cmd_t   cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output rrsjf_pkg::cmd_t   cmd_o,
  input  logic              pop_i
);
  import rrsjf_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= cmd_i;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && valid_o);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !push_i) |=> (cnt_q == 2'd0)) else $error("queue filled itself");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("full queue lost an entry");

endmodule

/* rtl/rrsjf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsjf_back: scheduling engine.
// Holds the slot table and both ready queues and carries out one command over
// several sequencer steps, then pulses one result.
// ----------------------------------------------------------------------------
module rrsjf_back #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned LEN_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rrsjf_pkg::cmd_t   cmd_i,
  output logic              pop_o,
  input  logic [15:0]       quantum_i,
  output logic              idle_o,
  output logic              res_valid_o,
  output logic [2:0]        status_o,
  output logic [3:0]        new_slot_o,
  output logic [3:0]        running_slot_o,
  output logic [3:0]        previous_slot_o
);
  import rrsjf_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned RW = LEN_BITS + 1;
  // Job bits actually taken from the command.
  localparam int unsigned JW = (LEN_BITS < JOB_W) ? LEN_BITS : JOB_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_INS    = 6'b000100,
    S_INS2   = 6'b001000,
    S_DISP   = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q;

  logic [SLOTS-1:0]  busy_q, high_q;
  logic [RW-1:0]     rem_q  [SLOTS];
  logic [15:0]       qnt_q  [SLOTS];
  logic [SW-1:0]     rr_q   [SLOTS];
  logic [SW-1:0]     sjf_q  [SLOTS];
  logic [SW-1:0]     head_q, tail_q;
  logic [CW-1:0]     rr_cnt_q, sjf_cnt_q;
  logic [SW-1:0]     cur_q, prev_q, new_q;
  logic              halted_q;
  cmd_t              cmd_q;
  logic [2:0]        st_q, sw_st_q;
  // Pending inserts: first the new thread, then optionally the old one.
  logic [SW-1:0]     ins_a_q, ins_b_q;
  logic              ins_b_v_q, disp_q;

  logic [SW-1:0] free_idx;
  logic          free_found;
  logic [SW-1:0] ins_s;
  logic [SLOTS-1:0] gt_vec;
  logic [CW-1:0] ins_pos;

  // Lowest free slot.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Insert position: first entry with a key strictly above the new key.
  assign ins_s = (state_q == S_INS2) ? ins_b_q : ins_a_q;
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      gt_vec[k] = (CW'(k) < sjf_cnt_q) && (rem_q[sjf_q[k]] > rem_q[ins_s]);
    end
    ins_pos = CW'(sjf_cnt_q);
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (gt_vec[k]) ins_pos = CW'(k);
    end
  end

  logic [SW-1:0] tail_nx, head_nx;
  assign tail_nx = (32'(tail_q) == SLOTS - 1) ? '0 : tail_q + SW'(1);
  assign head_nx = (32'(head_q) == SLOTS - 1) ? '0 : head_q + SW'(1);

  assign pop_o  = (state_q == S_IDLE) && valid_i;
  assign idle_o = (state_q == S_IDLE) && !valid_i;

  assign res_valid_o     = (state_q == S_OUT);
  assign status_o        = st_q;
  assign new_slot_o      = 4'(new_q);
  assign running_slot_o  = 4'(cur_q);
  assign previous_slot_o = 4'(prev_q);

  logic [15:0] qdec;
  assign qdec = qnt_q[cur_q] - 16'd1;

  // Table memories and queue contents (no reset needed beyond control).
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && !halted_q) begin
      if (cmd_q.op == OP_CREATE && free_found) begin
        rem_q[free_idx] <= RW'(cmd_q.job[JW-1:0]);
        if (!cmd_q.is_high) rr_q[tail_q] <= free_idx;
        else if (!high_q[cur_q]) rr_q[tail_q] <= cur_q;
      end else if (cmd_q.op == OP_TICK) begin
        if (high_q[cur_q]) begin
          if (rem_q[cur_q] != '0) rem_q[cur_q] <= rem_q[cur_q] - RW'(1);
        end else if (qdec == 16'd0) begin
          rr_q[tail_q] <= cur_q;
        end
      end
    end
    if (state_q == S_INS || state_q == S_INS2) begin
      for (int k = 1; k < SLOTS; k++) begin
        if (CW'(k) > ins_pos && CW'(k) <= sjf_cnt_q) sjf_q[k] <= sjf_q[k-1];
      end
      sjf_q[ins_pos[SW-1:0]] <= ins_s;
    end
    if (state_q == S_DISP && sjf_cnt_q != '0) begin
      for (int k = 1; k < SLOTS; k++) sjf_q[k-1] <= sjf_q[k];
    end
  end

  // Quantum left per slot; slot zero starts out running with the reset quantum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) qnt_q[k] <= (k == 0) ? QUANTUM_RST : 16'd0;
    end else if (state_q == S_EXEC && !halted_q) begin
      if (cmd_q.op == OP_CREATE && free_found) begin
        qnt_q[free_idx] <= quantum_i;
      end else if (cmd_q.op == OP_TICK && !high_q[cur_q]) begin
        qnt_q[cur_q] <= (qdec == 16'd0) ? quantum_i : qdec;
      end
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      busy_q    <= SLOTS'(1);
      high_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      rr_cnt_q  <= '0;
      sjf_cnt_q <= '0;
      cur_q     <= '0;
      prev_q    <= '0;
      new_q     <= '0;
      halted_q  <= 1'b0;
      st_q      <= ST_NOSWITCH;
      sw_st_q   <= ST_NOSWITCH;
      ins_a_q   <= '0;
      ins_b_q   <= '0;
      ins_b_v_q <= 1'b0;
      disp_q    <= 1'b0;
      cmd_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          prev_q    <= cur_q;
          new_q     <= '0;
          st_q      <= ST_NOSWITCH;
          disp_q    <= 1'b0;
          ins_b_v_q <= 1'b0;
          state_q   <= S_OUT;
          if (halted_q) begin
            st_q <= ST_HALTED;
          end else begin
            case (cmd_q.op)
              OP_CREATE: begin
                if (!free_found) begin
                  st_q <= ST_FULL;
                end else begin
                  busy_q[free_idx] <= 1'b1;
                  high_q[free_idx] <= cmd_q.is_high;
                  new_q            <= free_idx;
                  st_q             <= ST_CREATED;
                  sw_st_q          <= ST_PREEMPT;
                  if (!cmd_q.is_high) begin
                    tail_q   <= tail_nx;
                    rr_cnt_q <= rr_cnt_q + CW'(1);
                  end else begin
                    ins_a_q <= free_idx;
                    ins_b_q <= cur_q;
                    state_q <= S_INS;
                    if (!high_q[cur_q]) begin
                      tail_q   <= tail_nx;
                      rr_cnt_q <= rr_cnt_q + CW'(1);
                      disp_q   <= 1'b1;
                    end else if (rem_q[cur_q] > RW'(cmd_q.job[JW-1:0])) begin
                      ins_b_v_q <= 1'b1;
                      disp_q    <= 1'b1;
                    end
                  end
                end
              end
              OP_TICK: begin
                if (high_q[cur_q]) begin
                  if (rem_q[cur_q] == '0) begin
                    busy_q[cur_q] <= 1'b0;
                    sw_st_q       <= ST_EJECT;
                    state_q       <= S_DISP;
                  end
                end else if (qdec == 16'd0) begin
                  tail_q   <= tail_nx;
                  rr_cnt_q <= rr_cnt_q + CW'(1);
                  sw_st_q  <= ST_PREEMPT;
                  state_q  <= S_DISP;
                end
              end
              OP_EXIT: begin
                busy_q[cur_q] <= 1'b0;
                sw_st_q       <= ST_FINISH;
                state_q       <= S_DISP;
              end
              default: st_q <= ST_NOSWITCH;
            endcase
          end
        end
        S_INS: begin
          sjf_cnt_q <= sjf_cnt_q + CW'(1);
          if (ins_b_v_q) state_q <= S_INS2;
          else if (disp_q) state_q <= S_DISP;
          else state_q <= S_OUT;
        end
        S_INS2: begin
          sjf_cnt_q <= sjf_cnt_q + CW'(1);
          state_q   <= S_DISP;
        end
        S_DISP: begin
          state_q <= S_OUT;
          if (sjf_cnt_q != '0) begin
            sjf_cnt_q <= sjf_cnt_q - CW'(1);
            st_q      <= (sjf_q[0] == cur_q) ? ST_NOSWITCH : sw_st_q;
            cur_q     <= sjf_q[0];
          end else if (rr_cnt_q != '0) begin
            head_q   <= head_nx;
            rr_cnt_q <= rr_cnt_q - CW'(1);
            st_q     <= (rr_q[head_q] == cur_q) ? ST_NOSWITCH : sw_st_q;
            cur_q    <= rr_q[head_q];
          end else begin
            halted_q <= 1'b1;
            st_q     <= ST_DONE;
          end
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");
  a_rr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rr_cnt_q) <= SLOTS) else $error("round-robin count overflow");
  a_sjf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sjf_cnt_q) <= SLOTS) else $error("sorted queue count overflow");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt flag cleared");
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result held two cycles");

endmodule

/* rtl/rr_sjf_thread_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rr_sjf_thread_scheduler_top: round-robin / shortest-job-first scheduler.
// Each accepted command waits in the intake FIFO, then runs in the engine's
// sequencer: EXEC, one or two sorted inserts (INS, INS2) for a high create,
// DISP for a dispatch, then OUT with the result. The engine takes a new
// command only after the last result; meanwhile the FIFO holds up to two.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset (rst_ni low) clears the slot table to slot zero running, empty queues.
// ----------------------------------------------------------------------------
module rr_sjf_thread_scheduler_top #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned LEN_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic        is_high_i,
  input  logic [19:0] job_ticks_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  new_slot_o,
  output logic [3:0]  running_slot_o,
  output logic [3:0]  previous_slot_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrsjf_pkg::*;

  logic [15:0] quantum_q;
  cmd_t        in_cmd, q_cmd;
  logic        q_full, q_valid, q_pop, eng_idle;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, quantum_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= QUANTUM_RST;
    else if (psel && penable && pwrite && paddr == 2'd0) quantum_q <= pwdata[15:0];
  end

  assign busy = q_full;
  assign in_cmd = '{op: op_i, is_high: is_high_i, job: job_ticks_i};

  rrsjf_front u_front (
    .clk_i, .rst_ni, .push_i(start), .cmd_i(in_cmd), .full_o(q_full),
    .valid_o(q_valid), .cmd_o(q_cmd), .pop_i(q_pop)
  );

  rrsjf_back #(.SLOTS(SLOTS), .LEN_BITS(LEN_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .cmd_i(q_cmd), .pop_o(q_pop),
    .quantum_i(quantum_q), .idle_o(eng_idle), .res_valid_o(done_o),
    .status_o, .new_slot_o, .running_slot_o, .previous_slot_o
  );

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_idle |-> !q_valid) else $error("engine idle with queued command");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> busy) else $error("busy low while queue full");
  a_done_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !q_pop) else $error("pop during result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the round-robin / SJF thread scheduler.
// A directed table covers the corner cases. Random create, tick and exit
// traffic is then run under several quantum settings, and the run ends by
// draining the scheduler into its halted state. A command-level model in the
// bench predicts untyped results; each transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import rrsjf_pkg::*;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 2000;

  typedef struct {
    logic [2:0] status;
    logic [3:0] new_slot;
    logic [3:0] run_slot;
    logic [3:0] prev_slot;
  } sched_res_t;

  typedef struct {
    logic [1:0]  op;
    logic        hi;
    logic [19:0] job;
    bit          typed;
    sched_res_t  res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  op_i = OP_TICK;
  logic        is_high_i = 1'b0;
  logic [19:0] job_ticks_i = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        done_o;
  logic [2:0]  status_o;
  logic [3:0]  new_slot_o;
  logic [3:0]  running_slot_o;
  logic [3:0]  previous_slot_o;
  logic [31:0] prdata;
  logic        pready;

  rr_sjf_thread_scheduler_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .is_high_i      (is_high_i),
    .job_ticks_i    (job_ticks_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .new_slot_o     (new_slot_o),
    .running_slot_o (running_slot_o),
    .previous_slot_o(previous_slot_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scheduler shadow state.
  logic [15:0] m_quantum;
  bit          m_busy [NSLOT];
  bit          m_high [NSLOT];
  logic [20:0] m_rem [NSLOT];
  logic [15:0] m_qleft [NSLOT];
  logic [3:0]  m_rrq [NSLOT];
  logic [3:0]  m_rr_head;
  logic [3:0]  m_rr_tail;
  logic [4:0]  m_rr_cnt;
  logic [3:0]  m_sjf [NSLOT];
  logic [4:0]  m_sjf_cnt;
  logic [3:0]  m_cur;
  bit          m_halted;

  sched_res_t expected_q [$];
  int         err_cnt = 0;
  int         idle_cycles = 0;

  function automatic void rr_push(input logic [3:0] s);
    if (m_rr_cnt >= NSLOT) return;
    m_rrq[m_rr_tail] = s;
    m_rr_tail++;
    m_rr_cnt++;
  endfunction

  // Sorted insert by remaining ticks, after any equal keys.
  function automatic void sjf_insert(input logic [3:0] s);
    int pos;
    pos = 0;
    if (m_sjf_cnt >= NSLOT) return;
    while (pos < m_sjf_cnt && m_rem[m_sjf[pos]] <= m_rem[s]) pos++;
    for (int k = m_sjf_cnt; k > pos; k--) m_sjf[k] = m_sjf[k-1];
    m_sjf[pos] = s;
    m_sjf_cnt++;
  endfunction

  // Pick the next thread, sorted queue first, and report the status.
  function automatic logic [2:0] dispatch(input logic [2:0] sw_status);
    logic [3:0] nxt;
    if (m_sjf_cnt != 0) begin
      nxt = m_sjf[0];
      for (int k = 1; k < m_sjf_cnt; k++) m_sjf[k-1] = m_sjf[k];
      m_sjf_cnt--;
    end else if (m_rr_cnt != 0) begin
      nxt = m_rrq[m_rr_head];
      m_rr_head++;
      m_rr_cnt--;
    end else begin
      m_halted = 1'b1;
      return ST_DONE;
    end
    if (nxt == m_cur) return ST_NOSWITCH;
    m_cur = nxt;
    return sw_status;
  endfunction

  // Advance the shadow state by one command and return its result.
  function automatic sched_res_t predict_sched(input logic [1:0] op, input logic hi,
                                               input logic [19:0] job);
    sched_res_t r;
    logic [3:0] c;
    int i;
    r.status = ST_NOSWITCH;
    r.new_slot = '0;
    r.prev_slot = m_cur;
    c = m_cur;
    if (m_halted) begin
      r.status = ST_HALTED;
    end else begin
      case (op)
        OP_CREATE: begin
          i = 0;
          while (i < NSLOT && m_busy[i]) i++;
          if (i == NSLOT) begin
            r.status = ST_FULL;
          end else begin
            m_busy[i] = 1'b1;
            m_high[i] = hi;
            m_rem[i] = {1'b0, job};
            m_qleft[i] = m_quantum;
            r.new_slot = i[3:0];
            r.status = ST_CREATED;
            if (!hi) begin
              rr_push(i[3:0]);
            end else begin
              sjf_insert(i[3:0]);
              if (!m_high[c]) begin
                rr_push(c);
                r.status = dispatch(ST_PREEMPT);
              end else if (m_rem[c] > {1'b0, job}) begin
                sjf_insert(c);
                r.status = dispatch(ST_PREEMPT);
              end
            end
          end
        end
        OP_TICK: begin
          if (m_high[c]) begin
            if (m_rem[c] == 0) begin
              m_busy[c] = 1'b0;
              r.status = dispatch(ST_EJECT);
            end else begin
              m_rem[c] = m_rem[c] - 1'b1;
            end
          end else begin
            m_qleft[c] = m_qleft[c] - 1'b1;
            if (m_qleft[c] == 0) begin
              m_qleft[c] = m_quantum;
              rr_push(c);
              r.status = dispatch(ST_PREEMPT);
            end
          end
        end
        OP_EXIT: begin
          m_busy[c] = 1'b0;
          r.status = dispatch(ST_FINISH);
        end
        default: ;
      endcase
    end
    r.run_slot = m_cur;
    return r;
  endfunction

  // Issue one command and hold start until the transfer; then idle for gap.
  task automatic send_cmd(input logic [1:0] op, input logic hi, input logic [19:0] job,
                          input bit typed, input sched_res_t typed_res, input int gap);
    sched_res_t r;
    start <= 1'b1;
    op_i <= op;
    is_high_i <= hi;
    job_ticks_i <= job;
    do @(posedge clk_i); while (busy);
    r = predict_sched(op, hi, job);
    expected_q.push_back(typed ? typed_res : r);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [15:0] q);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {16'h0, q};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    m_quantum = q;
    @(posedge clk_i);
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected result transfer: status %0d", status_o);
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status || new_slot_o !== e.new_slot ||
            running_slot_o !== e.run_slot || previous_slot_o !== e.prev_slot) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("Mismatch: exp st=%0d new=%0d run=%0d prev=%0d, got st=%0d new=%0d run=%0d prev=%0d",
                     e.status, e.new_slot, e.run_slot, e.prev_slot,
                     status_o, new_slot_o, running_slot_o, previous_slot_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni || expected_q.size() == 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    dir_row_t   rows [23];
    sched_res_t none;
    logic [15:0] quanta [5];
    logic [1:0]  op;
    logic        hi;
    logic [19:0] job;
    int          sel;
    int          gap;
    bit          burst;

    m_quantum = 16'd20;
    for (int k = 0; k < NSLOT; k++) begin
      m_busy[k] = 1'b0;
      m_high[k] = 1'b0;
      m_rem[k] = '0;
      m_qleft[k] = '0;
      m_rrq[k] = '0;
      m_sjf[k] = '0;
    end
    m_busy[0] = 1'b1;
    m_qleft[0] = m_quantum;
    m_rr_head = '0;
    m_rr_tail = '0;
    m_rr_cnt = '0;
    m_sjf_cnt = '0;
    m_cur = '0;
    m_halted = 1'b0;
    none = '{ST_NOSWITCH, 4'd0, 4'd0, 4'd0};
    burst = 1'b0;

    // Directed rows: results typed in where they follow directly from reset.
    rows[0] = '{OP_TICK,   1'b0, 20'h0,     1'b1, '{ST_NOSWITCH, 4'd0, 4'd0, 4'd0}};
    rows[1] = '{OP_CREATE, 1'b0, 20'h0,     1'b1, '{ST_CREATED,  4'd1, 4'd0, 4'd0}};
    rows[2] = '{OP_CREATE, 1'b1, 20'hFFFFF, 1'b1, '{ST_PREEMPT,  4'd2, 4'd2, 4'd0}};
    rows[3] = '{2'd3,      1'b1, 20'hFFFFF, 1'b1, '{ST_NOSWITCH, 4'd0, 4'd2, 4'd2}};
    rows[4] = '{OP_CREATE, 1'b1, 20'h0,     1'b1, '{ST_PREEMPT,  4'd3, 4'd3, 4'd2}};
    rows[5] = '{OP_TICK,   1'b0, 20'h0,     1'b1, '{ST_EJECT,    4'd0, 4'd2, 4'd3}};
    // Equal key does not preempt.
    rows[6] = '{OP_CREATE, 1'b1, 20'hFFFFF, 1'b1, '{ST_CREATED,  4'd3, 4'd2, 4'd2}};
    rows[7] = '{OP_EXIT,   1'b0, 20'h0,     1'b1, '{ST_FINISH,   4'd0, 4'd3, 4'd2}};
    // Fill every slot, then two creates that find the table full.
    for (int k = 8; k < 23; k++) begin
      rows[k] = '{OP_CREATE, k[0], 20'(k * 37), 1'b0, none};
    end
    rows[9].job = 20'hAAAAA;
    rows[10].job = 20'h55555;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      send_cmd(rows[k].op, rows[k].hi, rows[k].job, rows[k].typed, rows[k].res,
               $urandom_range(0, 13));
    end
    drain();

    // Random phases under several quanta, extremes included.
    quanta[0] = 16'd1;
    quanta[1] = 16'hFFFF;
    quanta[2] = 16'd0;
    quanta[3] = 16'd3;
    quanta[4] = 16'($urandom_range(1, 40));
    foreach (quanta[p]) begin
      write_quantum(quanta[p]);
      for (int n = 0; n < 106; n++) begin
        sel = $urandom_range(0, 99);
        op = (sel < 35) ? OP_CREATE : (sel < 80) ? OP_TICK : (sel < 95) ? OP_EXIT : 2'd3;
        hi = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        job = (sel < 7) ? 20'($urandom_range(0, 6)) :
              (sel < 9) ? 20'($urandom_range(0, 300)) : 20'($urandom);
        // Keep the scheduler alive: with empty queues only creates are sent.
        if (m_rr_cnt == 0 && m_sjf_cnt == 0) op = OP_CREATE;
        if ($urandom_range(0, 19) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 13);
        send_cmd(op, hi, job, 1'b0, none, gap);
      end
      drain();
    end

    // Run every thread out until the scheduler halts, then poke it again.
    while (!m_halted) send_cmd(OP_EXIT, 1'b0, 20'h0, 1'b0, none, $urandom_range(0, 13));
    send_cmd(OP_CREATE, 1'b1, 20'h1, 1'b1, '{ST_HALTED, 4'd0, m_cur, m_cur}, 0);
    send_cmd(OP_TICK, 1'b0, 20'h0, 1'b1, '{ST_HALTED, 4'd0, m_cur, m_cur}, 3);
    send_cmd(OP_EXIT, 1'b0, 20'h0, 1'b1, '{ST_HALTED, 4'd0, m_cur, m_cur}, 0);
    drain();
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rrsjf_pkg.sv
rtl/rrsjf_front.sv
rtl/rrsjf_back.sv
rtl/rr_sjf_thread_scheduler_top.sv
tb/tb_top.sv
